>>> rtl/core/strm_pkg.sv
// Package: shared constants and types for the sparse table range minimum block.
package strm_pkg;
  localparam int unsigned DefMaxElements = 1024;
  localparam int unsigned DefLogLevels   = 11;
  localparam int unsigned DefValueWidth  = 32;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusRange  = 2'd1;
  localparam logic [1:0] StatusNoData = 2'd2;

  // One classified command handed from front to back.
  typedef struct packed {
    logic        op;
    logic [31:0] value;
    logic        last;
    logic [9:0]  range_low;
    logic [9:0]  range_high;
  } cmd_t;
endpackage

>>> rtl/core/strm_front.sv
// Front end: accepts input transactions and queues them for the back end.
module strm_front import strm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cmd_t        cmd_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output cmd_t        q_cmd_o
);
  // two-entry queue
  cmd_t       mem_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = mem_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= cmd_i;
    end
  end
endmodule

>>> rtl/core/strm_back.sv
// Back end: element store, sparse table build and query sequencer.
module strm_back import strm_pkg::*; #(
  parameter int unsigned MaxElements = DefMaxElements,
  parameter int unsigned LogLevels   = DefLogLevels,
  parameter int unsigned ValueWidth  = DefValueWidth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  cmd_t              q_cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [9:0]        min_index_o,
  output logic signed [31:0] min_value_o,
  output logic [1:0]        status_o
);
  localparam int unsigned AW = (MaxElements > 1) ? $clog2(MaxElements) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned LW = $clog2(LogLevels + 1);
  localparam int unsigned TD = LogLevels * MaxElements;
  localparam int unsigned TW = $clog2(TD);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StB0   = 4'd1;  // level 0 fill
  localparam logic [3:0] StBRa  = 4'd2;  // read table entry i
  localparam logic [3:0] StBRb  = 4'd3;  // read table entry i+half
  localparam logic [3:0] StBDa  = 4'd4;  // read element a
  localparam logic [3:0] StBDb  = 4'd5;  // read element b
  localparam logic [3:0] StBW   = 4'd6;  // compare and write
  localparam logic [3:0] StQTa  = 4'd7;
  localparam logic [3:0] StQTb  = 4'd8;
  localparam logic [3:0] StQDa  = 4'd9;
  localparam logic [3:0] StQDb  = 4'd10;
  localparam logic [3:0] StQC   = 4'd11;
  localparam logic [3:0] StQV   = 4'd12;
  localparam logic [3:0] StOut  = 4'd13;

  logic [ValueWidth-1:0] elem_mem [MaxElements];
  logic [AW-1:0]         tab_mem  [TD];

  logic [3:0]   st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rdy_q, rdy_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [CW-1:0] i_q, i_d;
  logic [AW-1:0] lo_q, hi_q;
  logic [AW-1:0] a_q, b_q;
  logic [ValueWidth-1:0] va_q;
  logic [9:0]    oidx_q;
  logic [31:0]   oval_q;
  logic [1:0]    ost_q;

  // table port
  logic          t_we;
  logic [TW-1:0] t_waddr, t_raddr;
  logic [AW-1:0] t_wdata, t_rdata_q;
  logic [AW-1:0] e_raddr;
  logic [ValueWidth-1:0] e_rdata_q;
  logic          e_we;

  logic [CW-1:0] len, half;
  logic [CW-1:0] span;
  logic [LW-1:0] qk;
  logic [ValueWidth-1:0] ext_val;
  logic          a_le_b;
  logic [CW-1:0] qlo_ext, qhi_ext;
  logic          is_load, bad_range;

  // first StOut cycle carries the fresh element read
  logic          out_valid_q_seen;
  logic [31:0]   val_now;
  logic [9:0]    idx_now;

  assign len  = CW'(1) << lvl_q;
  assign half = CW'(1) << (lvl_q - LW'(1));
  assign ext_val = ValueWidth'({{32{q_cmd_i.value[31]}}, q_cmd_i.value});
  assign a_le_b  = $signed(va_q) <= $signed(e_rdata_q);
  assign qlo_ext = CW'(q_cmd_i.range_low);
  assign qhi_ext = CW'(q_cmd_i.range_high);
  assign is_load = (q_cmd_i.op == OpLoad);
  assign bad_range = (qlo_ext > qhi_ext) || (qhi_ext >= cnt_q)
                     || (q_cmd_i.range_high > 10'(MaxElements - 1));

  // floor log2 of the span, capped at the top built level
  always_comb begin
    span = CW'(hi_q) - CW'(lo_q) + CW'(1);
    qk = '0;
    for (int j = 1; j < CW; j++) begin
      if (span[j]) qk = (j < LogLevels) ? LW'(j) : LW'(LogLevels - 1);
    end
  end

  function automatic logic [TW-1:0] taddr(logic [LW-1:0] k, logic [AW-1:0] i);
    return TW'(k) * TW'(MaxElements) + TW'(i);
  endfunction

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rdy_d = rdy_q; lvl_d = lvl_q; i_d = i_q;
    t_we = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = '0;
    e_we = 1'b0; e_raddr = '0;
    q_ready_o = 1'b0;
    unique case (st_q)
      StIdle: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          if (is_load) begin
            cnt_d = rdy_q ? '0 : cnt_q;
            rdy_d = 1'b0;
            if (cnt_d < CW'(MaxElements)) begin
              e_we  = 1'b1;
              cnt_d = cnt_d + CW'(1);
            end
            if (q_cmd_i.last) begin
              st_d = StB0;
              i_d  = '0;
            end
          end else if (!rdy_q || bad_range) begin
            st_d = StOut;
          end else begin
            st_d = StQTa;
          end
        end
      end
      StB0: begin
        if (i_q < cnt_q) begin
          t_we = 1'b1; t_waddr = taddr('0, i_q[AW-1:0]); t_wdata = i_q[AW-1:0];
          i_d = i_q + CW'(1);
        end else begin
          lvl_d = LW'(1); i_d = '0; st_d = StBRa;
        end
      end
      StBRa: begin
        if ((lvl_q >= LW'(LogLevels)) || (len > cnt_q)) begin
          rdy_d = 1'b1; st_d = StIdle;
        end else if (i_q + len > cnt_q) begin
          lvl_d = lvl_q + LW'(1); i_d = '0;
        end else begin
          t_raddr = taddr(lvl_q - LW'(1), i_q[AW-1:0]); st_d = StBRb;
        end
      end
      StBRb: begin
        t_raddr = taddr(lvl_q - LW'(1), AW'(i_q + half)); st_d = StBDa;
      end
      StBDa: begin
        e_raddr = a_q; st_d = StBDb;
      end
      StBDb: begin
        e_raddr = b_q; st_d = StBW;
      end
      StBW: begin
        t_we = 1'b1; t_waddr = taddr(lvl_q, i_q[AW-1:0]);
        t_wdata = a_le_b ? a_q : b_q;
        i_d = i_q + CW'(1); st_d = StBRa;
      end
      StQTa: begin
        t_raddr = taddr(qk, lo_q); st_d = StQTb;
      end
      StQTb: begin
        t_raddr = taddr(qk, AW'(CW'(hi_q) + CW'(1) - (CW'(1) << qk))); st_d = StQDa;
      end
      StQDa: begin
        e_raddr = a_q; st_d = StQDb;
      end
      StQDb: begin
        e_raddr = b_q; st_d = StQC;
      end
      StQC: begin
        st_d = StQV;
      end
      StQV: begin
        e_raddr = a_q; st_d = StOut;
      end
      StOut: begin
        if (out_ready_i) st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= '0; rdy_q <= 1'b0; lvl_q <= '0; i_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; rdy_q <= rdy_d; lvl_q <= lvl_d; i_q <= i_d;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (e_we) elem_mem[cnt_d[AW-1:0] - AW'(1)] <= ext_val;
    e_rdata_q <= elem_mem[e_raddr];
    if (t_we) tab_mem[t_waddr] <= t_wdata;
    t_rdata_q <= tab_mem[t_raddr];
  end

  // datapath registers: capture read data from the registered memory outputs
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i && !is_load) begin
      lo_q <= AW'(q_cmd_i.range_low);
      hi_q <= AW'(q_cmd_i.range_high);
      ost_q <= !rdy_q ? StatusNoData : (bad_range ? StatusRange : StatusOk);
      oidx_q <= '0;
      oval_q <= '0;
    end
    if (st_q == StBRb || st_q == StQTb) a_q <= t_rdata_q;
    if (st_q == StBDa || st_q == StQDa) b_q <= t_rdata_q;
    if (st_q == StBDb || st_q == StQDb) va_q <= e_rdata_q;
    if (st_q == StQC) a_q <= a_le_b ? a_q : b_q;
    if (st_q == StOut && ost_q == StatusOk && !out_valid_q_seen) begin
      oidx_q <= 10'(a_q);
      oval_q <= val_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q_seen <= 1'b0;
    else out_valid_q_seen <= (st_q == StOut) && !out_ready_i;
  end

  // low 32 bits of the element, sign-extended when the element is narrower
  assign val_now = 32'($signed(e_rdata_q));
  assign idx_now = 10'(a_q);

  assign out_valid_o = (st_q == StOut);
  assign status_o    = ost_q;
  assign min_index_o = (ost_q != StatusOk) ? 10'd0 : (out_valid_q_seen ? oidx_q : idx_now);
  assign min_value_o = (ost_q != StatusOk) ? 32'sd0
                       : $signed(out_valid_q_seen ? oval_q : val_now);
endmodule

>>> rtl/core/sparse_table_range_min_top.sv
// Top level of the sparse table range minimum block.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, op, value, last,   | into block
//           | range_low, range_high                     |
//   out     | out_valid_o/out_ready_i, min_index,       | out of block
//           | min_value, status                         |
//
// The back end stores a load while idle; the two-entry front queue lets
// loads stream. The item marked last starts the build: level 0 is filled,
// then each higher entry takes two table reads, two element reads, a
// compare and a write. A query does two table reads, two element reads,
// a compare and a reread. Reset clears the control registers, not the
// memories. Either side may stall; the front queue holds items meanwhile.
module sparse_table_range_min_top import strm_pkg::*; #(
  parameter int unsigned MaxElements = DefMaxElements,
  parameter int unsigned LogLevels   = DefLogLevels,
  parameter int unsigned ValueWidth  = DefValueWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  input  logic [9:0]         range_low_i,
  input  logic [9:0]         range_high_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         min_index_o,
  output logic signed [31:0] min_value_o,
  output logic [1:0]         status_o
);
  cmd_t cmd, q_cmd;
  logic q_valid, q_ready;

  assign cmd = '{op: op_i, value: value_i, last: last_i,
                 range_low: range_low_i, range_high: range_high_i};

  strm_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i(cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  strm_back #(
    .MaxElements(MaxElements), .LogLevels(LogLevels), .ValueWidth(ValueWidth)
  ) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_ready_i, .min_index_o, .min_value_o, .status_o
  );
endmodule
